@@ rtl/two_level_priority_queue_defines.svh @@
// assertion macros for the two-level priority queue
`ifndef TWO_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define TLPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define TLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tlpq_pkg.sv @@
// shared types and constants of the two-level priority queue
`default_nettype none

package tlpq_pkg;

  // command carried in the input user field
  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_t;

  // user field layout, lowest bit first
  localparam int USER_W       = 2;
  localparam int IN_USER_CMD  = 0;
  localparam int IN_USER_PRIO = 1;
  localparam int OUT_USER_OK  = 0;
  localparam int OUT_USER_HI  = 1;

endpackage

`default_nettype wire

@@ rtl/two_level_priority_queue.sv @@
// strict-priority scheduler over a high and a low circular queue
//
// input channel in_*: one beat is one command. in_tuser[0] is the command
// (0 enqueue, 1 dequeue), in_tuser[1] picks the high queue for an enqueue,
// in_tdata carries the word to enqueue.
// output channel out_*: exactly one result beat per command, in order.
// out_tuser[0] is ok, out_tuser[1] says the word came from the high queue,
// out_tdata is the dequeued word (zero for enqueues and failed dequeues).
// a dequeue serves the high queue whenever it holds anything, else the low.
// an enqueue into a full queue is dropped with ok low.
// throughput: one command per cycle while out_tready keeps up; pointers and
// counts update at accept, so back-to-back commands see each other at once.
// after accept, a result passes the synchronous ram read at the head pointer
// (the read stage) and then the output register before out_tvalid rises.
// reset clears pointers, counts and the valid flags; the queue rams are not
// cleared and need no clearing pass.
// when the receiver stalls, the read stage and the output register hold two
// results; in_tready then drops until out_tready returns.
`default_nettype none

module two_level_priority_queue #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // fields from bit 0: data_in
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]       in_tdata,
  // fields from bit 0: command, high_priority
  input  wire logic [tlpq_pkg::USER_W-1:0]           in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // fields from bit 0: data_out
  output logic      [((DATA_WIDTH+7)/8)*8-1:0]       out_tdata,
  // fields from bit 0: ok, from_high
  output logic      [tlpq_pkg::USER_W-1:0]           out_tuser
);

`include "two_level_priority_queue_defines.svh"

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // pointers and counts
  logic [PTR_W-1:0] hi_head_r, hi_head_nxt, hi_tail_r, hi_tail_nxt;
  logic [PTR_W-1:0] lo_head_r, lo_head_nxt, lo_tail_r, lo_tail_nxt;
  logic [CNT_W-1:0] hi_cnt_r, hi_cnt_nxt, lo_cnt_r, lo_cnt_nxt;

  // read stage and output register
  logic pend_valid_r, pend_valid_nxt;
  logic pend_ok_r, pend_rd_r, pend_hi_r;
  logic out_valid_r, out_valid_nxt;
  logic out_ok_r, out_hi_r;
  logic [DATA_WIDTH-1:0] out_data_r;

  logic                  in_acc, pend_adv;
  tlpq_pkg::cmd_t        cmd;
  logic                  prio;
  logic [DATA_WIDTH-1:0] word;
  logic                  hi_full, lo_full;
  logic                  enq_hi, enq_lo, deq_hi, deq_lo, cmd_ok;
  logic [DATA_WIDTH-1:0] hi_rdata, lo_rdata;

  // pointer advance with wrap at any depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // handshake
  assign pend_adv  = pend_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_valid_r || pend_adv;
  assign in_acc    = in_tvalid && in_tready;

  // command decode
  assign cmd     = tlpq_pkg::cmd_t'(in_tuser[tlpq_pkg::IN_USER_CMD]);
  assign prio    = in_tuser[tlpq_pkg::IN_USER_PRIO];
  assign word    = in_tdata[DATA_WIDTH-1:0];
  assign hi_full = (hi_cnt_r == CNT_W'(DEPTH));
  assign lo_full = (lo_cnt_r == CNT_W'(DEPTH));

  always_comb begin
    enq_hi = in_acc && (cmd == tlpq_pkg::CMD_ENQUEUE) && prio && !hi_full;
    enq_lo = in_acc && (cmd == tlpq_pkg::CMD_ENQUEUE) && !prio && !lo_full;
    deq_hi = in_acc && (cmd == tlpq_pkg::CMD_DEQUEUE) && (hi_cnt_r != '0);
    deq_lo = in_acc && (cmd == tlpq_pkg::CMD_DEQUEUE) && (hi_cnt_r == '0)
             && (lo_cnt_r != '0);
    cmd_ok = enq_hi || enq_lo || deq_hi || deq_lo;
  end

  // queue rams
  tlpq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_hi_ram (
    .clk   (clk),
    .we    (enq_hi),
    .waddr (hi_tail_r),
    .wdata (word),
    .re    (deq_hi),
    .raddr (hi_head_r),
    .rdata (hi_rdata)
  );

  tlpq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (enq_lo),
    .waddr (lo_tail_r),
    .wdata (word),
    .re    (deq_lo),
    .raddr (lo_head_r),
    .rdata (lo_rdata)
  );

  // next pointers and counts
  always_comb begin
    hi_head_nxt = deq_hi ? next_slot(hi_head_r) : hi_head_r;
    hi_tail_nxt = enq_hi ? next_slot(hi_tail_r) : hi_tail_r;
    lo_head_nxt = deq_lo ? next_slot(lo_head_r) : lo_head_r;
    lo_tail_nxt = enq_lo ? next_slot(lo_tail_r) : lo_tail_r;
    hi_cnt_nxt  = hi_cnt_r;
    if (enq_hi) begin
      hi_cnt_nxt = hi_cnt_r + CNT_W'(1);
    end else if (deq_hi) begin
      hi_cnt_nxt = hi_cnt_r - CNT_W'(1);
    end
    lo_cnt_nxt = lo_cnt_r;
    if (enq_lo) begin
      lo_cnt_nxt = lo_cnt_r + CNT_W'(1);
    end else if (deq_lo) begin
      lo_cnt_nxt = lo_cnt_r - CNT_W'(1);
    end
  end

  // next valid flags
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (in_acc) begin
      pend_valid_nxt = 1'b1;
    end else if (pend_adv) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (pend_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_head_r    <= '0;
      hi_tail_r    <= '0;
      lo_head_r    <= '0;
      lo_tail_r    <= '0;
      hi_cnt_r     <= '0;
      lo_cnt_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hi_head_r    <= hi_head_nxt;
      hi_tail_r    <= hi_tail_nxt;
      lo_head_r    <= lo_head_nxt;
      lo_tail_r    <= lo_tail_nxt;
      hi_cnt_r     <= hi_cnt_nxt;
      lo_cnt_r     <= lo_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_ok_r <= cmd_ok;
      pend_rd_r <= deq_hi || deq_lo;
      pend_hi_r <= deq_hi;
    end
  end

  // output register payload, ram data selected by source queue
  always_ff @(posedge clk) begin
    if (pend_adv) begin
      out_ok_r   <= pend_ok_r;
      out_hi_r   <= pend_hi_r;
      out_data_r <= !pend_rd_r ? '0 : (pend_hi_r ? hi_rdata : lo_rdata);
    end
  end

  // output ports
  always_comb begin
    out_tvalid                        = out_valid_r;
    out_tdata                         = TDATA_W'(out_data_r);
    out_tuser                         = '0;
    out_tuser[tlpq_pkg::OUT_USER_OK]  = out_ok_r;
    out_tuser[tlpq_pkg::OUT_USER_HI]  = out_hi_r;
  end

  // checks
  `TLPQ_ASSERT_SAME(a_hi_cnt_range, clk, rst_n, 1'b1, hi_cnt_r <= CNT_W'(DEPTH),
    "high queue count above depth")
  `TLPQ_ASSERT_SAME(a_lo_cnt_range, clk, rst_n, 1'b1, lo_cnt_r <= CNT_W'(DEPTH),
    "low queue count above depth")
  `TLPQ_ASSERT_NEXT(a_hi_deq_count, clk, rst_n, deq_hi,
    hi_cnt_r == $past(hi_cnt_r) - CNT_W'(1) && lo_cnt_r == $past(lo_cnt_r),
    "high dequeue did not take exactly one word from the high queue")
  `TLPQ_ASSERT_SAME(a_from_high_ok, clk, rst_n,
    out_valid_r && out_tuser[tlpq_pkg::OUT_USER_HI],
    out_tuser[tlpq_pkg::OUT_USER_OK],
    "result from high queue without ok")

endmodule

`default_nettype wire

@@ rtl/tlpq_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module tlpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_two_level_priority_queue.sv @@
// self-checking testbench for the two-level strict-priority queue
module tb_two_level_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpq_pkg::*;

  localparam int DEPTH        = 32;
  localparam int DATA_WIDTH   = 16;
  localparam int TDATA_W      = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int TOTAL_ITEMS  = 1450;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int IDLE_PCT     = 26;

  // one result beat as the scheduler reports it
  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] word;
    logic                  from_high;
  } result_t;

  // one row of the directed table; reps repeats the row with word + k
  typedef struct packed {
    cmd_t                  cmd;
    logic                  prio;
    logic [DATA_WIDTH-1:0] word;
    logic [7:0]            reps;
    logic                  typed;
    result_t               res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic [USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;

  // side information travelling with each offered beat
  logic row_typed = 1'b0;
  result_t row_exp = '0;

  // traffic shaping controls
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  // scheduler mirror state
  logic [DATA_WIDTH-1:0] high_words [DEPTH];
  logic [DATA_WIDTH-1:0] low_words [DEPTH];
  int unsigned high_rd = 0, high_wr = 0, high_fill = 0;
  int unsigned low_rd = 0, low_wr = 0, low_fill = 0;

  result_t pending_results [$];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int n_checked = 0;
  int n_refused = 0;
  int n_empty_deq = 0;
  int n_served_high = 0;
  int n_served_low = 0;

  two_level_priority_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // fields from bit 0: data_in
    .in_tuser   (in_tuser),   // fields from bit 0: command, high_priority
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // fields from bit 0: data_out
    .out_tuser  (out_tuser)   // fields from bit 0: ok, from_high
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // strict-priority decision and queue update for one accepted command
  function automatic result_t arbitrate_command(input cmd_t cmd, input logic prio,
                                                input logic [DATA_WIDTH-1:0] word);
    result_t r;
    r = '0;
    if (cmd == CMD_ENQUEUE) begin
      if (prio) begin
        if (high_fill < DEPTH) begin
          high_words[high_wr] = word;
          high_wr = (high_wr + 1) % DEPTH;
          high_fill++;
          r.ok = 1'b1;
        end
      end else begin
        if (low_fill < DEPTH) begin
          low_words[low_wr] = word;
          low_wr = (low_wr + 1) % DEPTH;
          low_fill++;
          r.ok = 1'b1;
        end
      end
      if (!r.ok) n_refused++;
    end else if (high_fill != 0) begin
      r.word = high_words[high_rd];
      high_rd = (high_rd + 1) % DEPTH;
      high_fill--;
      r.ok = 1'b1;
      r.from_high = 1'b1;
      n_served_high++;
    end else if (low_fill != 0) begin
      r.word = low_words[low_rd];
      low_rd = (low_rd + 1) % DEPTH;
      low_fill--;
      r.ok = 1'b1;
      n_served_low++;
    end else begin
      n_empty_deq++;
    end
    return r;
  endfunction

  // beat monitor: check results first, then predict newly accepted commands
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          flag_error("result beat with nothing expected");
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (out_tuser[OUT_USER_OK] !== want.ok)
            flag_error($sformatf("ok got %b want %b", out_tuser[OUT_USER_OK], want.ok));
          if (out_tdata[DATA_WIDTH-1:0] !== want.word)
            flag_error($sformatf("data got %h want %h", out_tdata[DATA_WIDTH-1:0],
                                 want.word));
          if (out_tuser[OUT_USER_HI] !== want.from_high)
            flag_error($sformatf("from_high got %b want %b", out_tuser[OUT_USER_HI],
                                 want.from_high));
        end
      end
      if (in_tvalid && in_tready) begin
        got = arbitrate_command(cmd_t'(in_tuser[IN_USER_CMD]), in_tuser[IN_USER_PRIO],
                                in_tdata[DATA_WIDTH-1:0]);
        pending_results.push_back(row_typed ? row_exp : got);
      end
    end
  end

  // receiver: random stalls, a calm stretch and one long hold-off
  initial begin : receiver
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // offer one command beat and wait until it is taken
  task automatic send_item(input cmd_t cmd, input logic prio,
                           input logic [DATA_WIDTH-1:0] word,
                           input logic typed, input result_t res);
    logic [USER_W-1:0] user;
    user = '0;
    user[IN_USER_CMD] = cmd;
    user[IN_USER_PRIO] = prio;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= TDATA_W'(word);
    in_tuser <= user;
    row_typed <= typed;
    row_exp <= res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // directed table: empty queues, priority order, ignored data, high queue full
  row_t directed_rows [17] = '{
    '{CMD_DEQUEUE, 1'b0, 16'h0000, 8'd1,  1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{CMD_DEQUEUE, 1'b1, 16'hFFFF, 8'd1,  1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b0, 16'h0000, 8'd1,  1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b0, 16'hA5A5, 8'd1,  1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b1, 16'hFFFF, 8'd1,  1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b1, 16'h8001, 8'd1,  1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{CMD_DEQUEUE, 1'b0, 16'h1234, 8'd1,  1'b1, '{1'b1, 16'hFFFF, 1'b1}},
    '{CMD_DEQUEUE, 1'b0, 16'h0000, 8'd1,  1'b1, '{1'b1, 16'h8001, 1'b1}},
    '{CMD_DEQUEUE, 1'b1, 16'hFFFF, 8'd1,  1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{CMD_DEQUEUE, 1'b0, 16'h5A5A, 8'd1,  1'b1, '{1'b1, 16'hA5A5, 1'b0}},
    '{CMD_DEQUEUE, 1'b0, 16'h0000, 8'd1,  1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b1, 16'h4000, 8'd32, 1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b1, 16'hFFFF, 8'd1,  1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b0, 16'h5555, 8'd1,  1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{CMD_DEQUEUE, 1'b0, 16'h0000, 8'd1,  1'b1, '{1'b1, 16'h4000, 1'b1}},
    '{CMD_ENQUEUE, 1'b1, 16'hAAAA, 8'd1,  1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{CMD_ENQUEUE, 1'b1, 16'h0000, 8'd1,  1'b1, '{1'b0, 16'h0000, 1'b0}}
  };

  // main sequence
  initial begin : stimulus
    int mode;
    int burst;
    int enq_pct;
    int high_pct;
    cmd_t cmd;
    logic prio;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_item(directed_rows[r].cmd, directed_rows[r].prio,
                  DATA_WIDTH'(directed_rows[r].word + k),
                  directed_rows[r].typed, directed_rows[r].res);
      end
    end

    // random bursts: balanced, filling, draining and high-heavy mixes
    while (items_sent < TOTAL_ITEMS) begin
      mode = $urandom_range(0, 3);
      burst = $urandom_range(16, 64);
      case (mode)
        0: begin enq_pct = 50; high_pct = 50; end
        1: begin enq_pct = 85; high_pct = 40; end
        2: begin enq_pct = 15; high_pct = 50; end
        default: begin enq_pct = 70; high_pct = 90; end
      endcase
      repeat (burst) begin
        if (items_sent == 400) hold_req <= 1'b1;
        if (items_sent == 800) calm <= 1'b1;
        if (items_sent == 1000) calm <= 1'b0;
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
        prio = ($urandom_range(0, 99) < high_pct);
        send_item(cmd, prio, DATA_WIDTH'($urandom), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;
    // let the monitor record the last accepted beat
    @(posedge clk);

    // drain, then watch for stray beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d commands sent, %0d results checked, %0d full-queue refusals",
             items_sent, n_checked, n_refused);
    $display("%0d empty dequeues, %0d words from the high queue, %0d from the low",
             n_empty_deq, n_served_high, n_served_low);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
